// ===== src/pmsfp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmsfp_pkg
// Types and fixed constants shared by the sensor frame parser modules.
// ----------------------------------------------------------------------------
package pmsfp_pkg;

	localparam logic [7:0] HDR_FIRST  = 8'h42;
	localparam logic [7:0] HDR_SECOND = 8'h4D;

	typedef enum logic [1:0] {
		ST_WORD    = 2'd0,
		ST_BAD_HDR = 2'd1,
		ST_BAD_SUM = 2'd2
	} status_t;

	// one entry of the queue between parser and drain
	typedef struct packed {
		status_t status;
		logic    bank;
	} cmd_t;

	// drain reports a word bank as free again
	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

endpackage

// ===== src/pmsfp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmsfp_in_if
// Received byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pmsfp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== src/pmsfp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmsfp_out_if
// Parsed result channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface pmsfp_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  frame_status;
	logic [3:0]  word_index;
	logic [15:0] word_value;
	logic        last_result;

	modport source (output valid, output frame_status, output word_index,
		output word_value, output last_result, input ready);
	modport sink (input valid, input frame_status, input word_index,
		input word_value, input last_result, output ready);
endinterface

// ===== src/pmsfp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmsfp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module pmsfp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/pmsfp_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmsfp_cmd_fifo
// Two-entry queue of frame outcomes between the byte parser and the drain.
// ----------------------------------------------------------------------------
module pmsfp_cmd_fifo import pmsfp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic not_empty
);

	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       entry_q [2];

	assign full      = cnt_q[1];
	assign not_empty = (cnt_q != 2'd0);
	assign pop_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== src/pmsfp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmsfp_front
// Byte parser: header check, word assembly into a ping-pong word store,
// running sum and checksum compare. Pushes one outcome per finished frame and per rejected header byte.
// ----------------------------------------------------------------------------
module pmsfp_front import pmsfp_pkg::*; #(
	parameter int WORD_COUNT = 14
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	pmsfp_in_if.sink                               rx,
	output logic                                   push,
	output cmd_t                                   push_cmd,
	input  logic                                   q_full,
	input  rel_t                                   rel,
	output logic                                   wr_en,
	output logic [((WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1):0] wr_addr,
	output logic [15:0]                            wr_data
);

	localparam int IDX_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int DATA_END = 2 + 2 * WORD_COUNT;
	localparam int POS_W    = $clog2(DATA_END + 2);

	logic [POS_W-1:0] pos_q, pos_d;
	logic [15:0]      sum_q, sum_d;
	logic [7:0]       hi_q;
	logic             wbank_q;
	logic [1:0]       busy_q, busy_d;
	logic             set_busy;
	logic             in_data;
	logic             acc;
	logic [POS_W-1:0] off;
	logic [7:0]       b;

	assign b       = rx.rx_byte;
	assign in_data = (pos_q >= POS_W'(2)) && (pos_q < POS_W'(DATA_END));
	assign off     = pos_q - POS_W'(2);

	// stall while the bank being filled still drains
	assign rx.ready = !q_full && !(in_data && busy_q[wbank_q]);
	assign acc      = rx.valid && rx.ready;

	assign wr_addr = {wbank_q, IDX_W'(off >> 1)};
	assign wr_data = {hi_q, b};

	always_comb begin
		push            = 1'b0;
		push_cmd.status = ST_WORD;
		push_cmd.bank   = wbank_q;
		pos_d           = pos_q;
		sum_d           = sum_q;
		set_busy        = 1'b0;
		wr_en           = 1'b0;
		if (acc) begin
			if (pos_q == POS_W'(0)) begin
				if (b == HDR_FIRST) begin
					pos_d = POS_W'(1);
					sum_d = {8'h00, b};
				end else begin
					push            = 1'b1;
					push_cmd.status = ST_BAD_HDR;
					sum_d           = 16'h0000;
				end
			end else if (pos_q == POS_W'(1)) begin
				if (b == HDR_SECOND) begin
					pos_d = POS_W'(2);
					sum_d = sum_q + {8'h00, b};
				end else begin
					push            = 1'b1;
					push_cmd.status = ST_BAD_HDR;
					pos_d           = POS_W'(0);
					sum_d           = 16'h0000;
				end
			end else if (in_data) begin
				sum_d = sum_q + {8'h00, b};
				pos_d = pos_q + POS_W'(1);
				wr_en = off[0];
			end else if (pos_q == POS_W'(DATA_END)) begin
				if (b == sum_q[15:8]) begin
					pos_d = pos_q + POS_W'(1);
				end else begin
					push            = 1'b1;
					push_cmd.status = ST_BAD_SUM;
					pos_d           = POS_W'(0);
					sum_d           = 16'h0000;
				end
			end else begin
				push  = 1'b1;
				pos_d = POS_W'(0);
				sum_d = 16'h0000;
				if (b == sum_q[7:0]) begin
					set_busy = 1'b1;
				end else begin
					push_cmd.status = ST_BAD_SUM;
				end
			end
		end
	end

	always_comb begin
		busy_d = busy_q;
		if (rel.valid) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (set_busy) begin
			busy_d[wbank_q] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			sum_q   <= 16'h0000;
			wbank_q <= 1'b0;
			busy_q  <= 2'b00;
		end else begin
			pos_q  <= pos_d;
			sum_q  <= sum_d;
			busy_q <= busy_d;
			if (set_busy) begin
				wbank_q <= ~wbank_q;
			end
		end
	end

	// high byte waits here until its low byte arrives
	always_ff @(posedge clk) begin
		if (acc && in_data && !off[0]) begin
			hi_q <= b;
		end
	end

endmodule

// ===== src/pmsfp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmsfp_back
// Drain: pops frame outcomes, emits error results directly and reads the
// stored words of a good frame out of the word store one by one.
// ----------------------------------------------------------------------------
module pmsfp_back import pmsfp_pkg::*; #(
	parameter int WORD_COUNT = 14
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   q_valid,
	input  cmd_t                                   q_cmd,
	output logic                                   q_pop,
	output logic                                   rd_en,
	output logic [((WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1):0] rd_addr,
	input  logic [15:0]                            rd_data,
	output rel_t                                   rel,
	pmsfp_out_if.source                            result
);

	localparam int IDX_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORD_COUNT - 1);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_FETCH = 3'b010,
		S_SHOW  = 3'b100
	} state_t;

	state_t           state_q;
	logic             ovalid_q;
	status_t          status_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0]      value_q;
	logic             last_q;
	logic             bank_q;
	logic             out_fire;
	logic             next_word;

	assign out_fire  = ovalid_q && result.ready;
	assign q_pop     = (state_q == S_IDLE) && q_valid && !ovalid_q;
	assign next_word = (state_q == S_SHOW) && out_fire && !last_q;

	assign rd_en   = (q_pop && (q_cmd.status == ST_WORD)) || next_word;
	assign rd_addr = q_pop ? {q_cmd.bank, IDX_W'(0)} : {bank_q, idx_q + IDX_W'(1)};

	assign rel.valid = (state_q == S_SHOW) && out_fire && last_q;
	assign rel.bank  = bank_q;

	assign result.valid        = ovalid_q;
	assign result.frame_status = status_q;
	assign result.word_index   = 4'(idx_q);
	assign result.word_value   = value_q;
	assign result.last_result  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (out_fire) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						if (q_cmd.status == ST_WORD) begin
							state_q <= S_FETCH;
						end else begin
							ovalid_q <= 1'b1;
						end
					end
				end
				S_FETCH: begin
					ovalid_q <= 1'b1;
					state_q  <= S_SHOW;
				end
				S_SHOW: begin
					if (out_fire) begin
						state_q <= last_q ? S_IDLE : S_FETCH;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			status_q <= q_cmd.status;
			bank_q   <= q_cmd.bank;
			idx_q    <= '0;
			value_q  <= 16'h0000;
			last_q   <= 1'b1;
		end
		if (state_q == S_FETCH) begin
			status_q <= ST_WORD;
			value_q  <= rd_data;
			last_q   <= (idx_q == LAST_IDX);
		end
		if (next_word) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

endmodule

// ===== src/pm_sensor_frame_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pm_sensor_frame_parser
// Byte-serial parser for the 32-byte particulate sensor frame.
// An error result passes the outcome queue and the output register; the
//   words of a good frame, after its outcome leaves the queue, pass the
//   registered word store read and the output register. One byte per cycle
//   in while not stalled; a word is read only once the prior result is taken.
// Input stalls when the outcome queue is full or the word bank being filled
//   is still draining. Reset clears parser, queue and drain control.
// ----------------------------------------------------------------------------
module pm_sensor_frame_parser import pmsfp_pkg::*; #(
	parameter int WORD_COUNT = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	pmsfp_in_if.sink    rx,
	pmsfp_out_if.source result
);

	localparam int IDX_W  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int ADDR_W = IDX_W + 1;

	logic              push;
	cmd_t              push_cmd;
	logic              q_full;
	logic              q_pop;
	cmd_t              q_cmd;
	logic              q_valid;
	rel_t              rel;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [15:0]       wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [15:0]       rd_data;

	pmsfp_front #(.WORD_COUNT(WORD_COUNT)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full),
		.rel      (rel),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data)
	);

	pmsfp_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.pop_cmd   (q_cmd),
		.not_empty (q_valid)
	);

	// two banks of words: one fills while the other drains
	pmsfp_ram #(.WIDTH(16), .DEPTH(1 << ADDR_W)) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	pmsfp_back #(.WORD_COUNT(WORD_COUNT)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pop   (q_pop),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.rel     (rel),
		.result  (result)
	);

endmodule

// ===== src/pmsfp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmsfp_checker
// Port-level checks on the result channel of the frame parser.
// ----------------------------------------------------------------------------
module pmsfp_checker import pmsfp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        valid,
	input logic        ready,
	input logic [1:0]  frame_status,
	input logic [3:0]  word_index,
	input logic [15:0] word_value,
	input logic        last_result
);

	// stalled transaction keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(frame_status) && $stable(word_index)
			&& $stable(word_value) && $stable(last_result))
		else $error("result changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> (frame_status == ST_WORD) || (frame_status == ST_BAD_HDR)
			|| (frame_status == ST_BAD_SUM))
		else $error("unknown frame status");

	// an error result stands alone with empty fields
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		valid && (frame_status != ST_WORD) |->
			last_result && (word_index == 4'd0) && (word_value == 16'h0000))
		else $error("malformed error result");

	a_rst: assert property (@(posedge clk) !arst_n |-> !valid)
		else $error("result valid during reset");

endmodule

bind pm_sensor_frame_parser pmsfp_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (result.valid),
	.ready        (result.ready),
	.frame_status (result.frame_status),
	.word_index   (result.word_index),
	.word_value   (result.word_value),
	.last_result  (result.last_result)
);
